>>> rtl/i2r_pkg.sv
`default_nettype none

package i2r_pkg;

    // Field widths of the converter.
    localparam int unsigned VALUE_W  = 12;
    localparam int unsigned LETTER_W = 7;
    localparam int unsigned AMT_W    = 10;
    localparam int unsigned STEP_W   = 5;

    // ASCII codes of the numeral letters.
    localparam logic [LETTER_W-1:0] LTR_C = 7'h43;
    localparam logic [LETTER_W-1:0] LTR_D = 7'h44;
    localparam logic [LETTER_W-1:0] LTR_I = 7'h49;
    localparam logic [LETTER_W-1:0] LTR_L = 7'h4C;
    localparam logic [LETTER_W-1:0] LTR_M = 7'h4D;
    localparam logic [LETTER_W-1:0] LTR_V = 7'h56;
    localparam logic [LETTER_W-1:0] LTR_X = 7'h58;

    // Entry points of the program: thousands, then one group of six steps per digit.
    localparam logic [STEP_W-1:0] ST_THOU = 5'd0;
    localparam logic [STEP_W-1:0] ST_HUND = 5'd1;
    localparam logic [STEP_W-1:0] ST_TENS = 5'd7;
    localparam logic [STEP_W-1:0] ST_UNIT = 5'd13;
    localparam logic [STEP_W-1:0] ST_END  = 5'd19;

    // One control word. A step passes when the remainder is at least thresh;
    // on a pass it emits letter, subtracts sub_amt and jumps to next_pass.
    typedef struct packed {
        logic [AMT_W-1:0]    thresh;
        logic [AMT_W-1:0]    sub_amt;
        logic [LETTER_W-1:0] letter;
        logic [STEP_W-1:0]   next_pass;
        logic [STEP_W-1:0]   next_fail;
    } uword_t;

    // Sequencer to datapath.
    typedef struct packed {
        logic   load;
        logic   active;
        uword_t word;
    } ctrl_t;

    // Datapath to sequencer.
    typedef struct packed {
        logic pass;
        logic zero_after;
    } status_t;

    function automatic uword_t mk_word(
        input logic [AMT_W-1:0]    thresh,
        input logic [AMT_W-1:0]    sub_amt,
        input logic [LETTER_W-1:0] letter,
        input logic [STEP_W-1:0]   next_pass,
        input logic [STEP_W-1:0]   next_fail
    );
        uword_t w;
        w.thresh    = thresh;
        w.sub_amt   = sub_amt;
        w.letter    = letter;
        w.next_pass = next_pass;
        w.next_fail = next_fail;
        return w;
    endfunction

    // Control store. Each digit group tests nine, five, four and one in turn;
    // the second letter of a subtractive pair is an unconditional step.
    function automatic uword_t urom(input logic [STEP_W-1:0] step);
        uword_t w;
        unique case (step)
            5'd0:  w = mk_word(10'd1000, 10'd1000, LTR_M, ST_THOU,    ST_HUND);
            5'd1:  w = mk_word(10'd900,  10'd0,    LTR_C, 5'd2,       5'd3);
            5'd2:  w = mk_word(10'd0,    10'd900,  LTR_M, ST_TENS,    ST_TENS);
            5'd3:  w = mk_word(10'd500,  10'd500,  LTR_D, 5'd6,       5'd4);
            5'd4:  w = mk_word(10'd400,  10'd0,    LTR_C, 5'd5,       5'd6);
            5'd5:  w = mk_word(10'd0,    10'd400,  LTR_D, ST_TENS,    ST_TENS);
            5'd6:  w = mk_word(10'd100,  10'd100,  LTR_C, 5'd6,       ST_TENS);
            5'd7:  w = mk_word(10'd90,   10'd0,    LTR_X, 5'd8,       5'd9);
            5'd8:  w = mk_word(10'd0,    10'd90,   LTR_C, ST_UNIT,    ST_UNIT);
            5'd9:  w = mk_word(10'd50,   10'd50,   LTR_L, 5'd12,      5'd10);
            5'd10: w = mk_word(10'd40,   10'd0,    LTR_X, 5'd11,      5'd12);
            5'd11: w = mk_word(10'd0,    10'd40,   LTR_L, ST_UNIT,    ST_UNIT);
            5'd12: w = mk_word(10'd10,   10'd10,   LTR_X, 5'd12,      ST_UNIT);
            5'd13: w = mk_word(10'd9,    10'd0,    LTR_I, 5'd14,      5'd15);
            5'd14: w = mk_word(10'd0,    10'd9,    LTR_X, ST_END,     ST_END);
            5'd15: w = mk_word(10'd5,    10'd5,    LTR_V, 5'd18,      5'd16);
            5'd16: w = mk_word(10'd4,    10'd0,    LTR_I, 5'd17,      5'd18);
            5'd17: w = mk_word(10'd0,    10'd4,    LTR_V, ST_END,     ST_END);
            5'd18: w = mk_word(10'd1,    10'd1,    LTR_I, 5'd18,      ST_END);
            default: w = mk_word(10'd1,  10'd1,    LTR_I, ST_END,     ST_END);
        endcase
        return w;
    endfunction

endpackage

`default_nettype wire

>>> rtl/i2r_dp.sv
`default_nettype none

module i2r_dp (
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    input  wire i2r_pkg::ctrl_t                     ctrl,
    input  wire logic [i2r_pkg::VALUE_W-1:0]        value,
    output i2r_pkg::status_t                        status,
    output logic [i2r_pkg::LETTER_W-1:0]            letter,
    output logic                                    last,
    output logic                                    strobe
);

    logic [i2r_pkg::VALUE_W-1:0]  rem_reg;
    logic [i2r_pkg::VALUE_W-1:0]  rem_next;
    logic [i2r_pkg::VALUE_W-1:0]  rem_after;
    logic [i2r_pkg::LETTER_W-1:0] letter_reg;
    logic                         last_reg;
    logic                         strobe_reg;
    logic                         pass;
    logic                         emit;

    // Compare against the step's threshold and subtract on a pass.
    always_comb
    begin
        pass      = rem_reg >= {{(i2r_pkg::VALUE_W-i2r_pkg::AMT_W){1'b0}}, ctrl.word.thresh};
        emit      = ctrl.active && pass;
        rem_after = rem_reg - {{(i2r_pkg::VALUE_W-i2r_pkg::AMT_W){1'b0}}, ctrl.word.sub_amt};
        if (ctrl.load)
        begin
            rem_next = value;
        end
        else if (emit)
        begin
            rem_next = rem_after;
        end
        else
        begin
            rem_next = rem_reg;
        end
        status.pass       = pass;
        status.zero_after = rem_after == '0;
    end

    // Remainder register.
    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
    end

    // Result beat register: one beat per emitted letter.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            strobe_reg <= 1'b0;
        end
        else
        begin
            strobe_reg <= emit;
        end
    end

    always_ff @(posedge clk)
    begin
        if (emit)
        begin
            letter_reg <= ctrl.word.letter;
            last_reg   <= rem_after == '0;
        end
    end

    assign letter = letter_reg;
    assign last   = last_reg;
    assign strobe = strobe_reg;

endmodule

`default_nettype wire

>>> rtl/i2r_seq.sv
`default_nettype none

module i2r_seq (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               go,
    input  wire logic               load,
    input  wire i2r_pkg::status_t   status,
    output i2r_pkg::ctrl_t          ctrl,
    output logic                    busy
);

    logic [i2r_pkg::STEP_W-1:0] step_reg;
    logic [i2r_pkg::STEP_W-1:0] step_next;
    logic                       busy_reg;
    logic                       busy_next;
    i2r_pkg::uword_t            word;

    // Fetch the control word of the current step.
    assign word = i2r_pkg::urom(step_reg);

    // Step counter with conditional jump; the run ends when the remainder drains.
    always_comb
    begin
        step_next = step_reg;
        busy_next = busy_reg;
        if (go)
        begin
            step_next = i2r_pkg::ST_THOU;
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            step_next = status.pass ? word.next_pass : word.next_fail;
            if ((status.pass && status.zero_after) || step_reg == i2r_pkg::ST_END)
            begin
                busy_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg <= i2r_pkg::ST_THOU;
            busy_reg <= 1'b0;
        end
        else
        begin
            step_reg <= step_next;
            busy_reg <= busy_next;
        end
    end

    always_comb
    begin
        ctrl.load   = load;
        ctrl.active = busy_reg && step_reg != i2r_pkg::ST_END;
        ctrl.word   = word;
    end

    assign busy = busy_reg;

endmodule

`default_nettype wire

>>> rtl/integer_to_roman_numeral.sv
`default_nettype none

// Integer to Roman numeral converter.
// Command channel: drive value and raise start; the value is taken at a rising
// edge where start is high and busy is low. A value of zero is taken and gives
// no beats; busy stays low.
// Result channel: one beat per numeral letter, most significant letter first.
// letter holds the ASCII code and last marks the final letter; each beat is
// valid for exactly one cycle while strobe is high. The receiver cannot stall,
// so every beat must be taken when it appears.
// Timing: the value is loaded into the remainder register, and each letter is
// registered into letter and strobe from the step that emits it. Each step
// either emits one letter or is a digit test that emits nothing. A microcoded
// sequencer walks a 19-step control store, one step per cycle, with one compare
// and subtract on the remainder register per step.
// busy drops with the final letter's beat, and a new value may be taken while
// that beat is still on the ports.
// Reset: rst_n clears the sequencer and the strobe; no beat is pending after it.

module integer_to_roman_numeral (
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    input  wire logic                               start,
    output logic                                    busy,
    input  wire logic [i2r_pkg::VALUE_W-1:0]        value,
    output logic [i2r_pkg::LETTER_W-1:0]            letter,
    output logic                                    last,
    output logic                                    strobe
);

    logic              accept;
    logic              go;
    i2r_pkg::ctrl_t    ctrl;
    i2r_pkg::status_t  status;

    // A nonzero value starts the program; zero is taken and dropped.
    assign accept = start && !busy;
    assign go     = accept && value != '0;

    i2r_seq u_seq (
        .clk    (clk),
        .rst_n  (rst_n),
        .go     (go),
        .load   (accept),
        .status (status),
        .ctrl   (ctrl),
        .busy   (busy)
    );

    i2r_dp u_dp (
        .clk    (clk),
        .rst_n  (rst_n),
        .ctrl   (ctrl),
        .value  (value),
        .status (status),
        .letter (letter),
        .last   (last),
        .strobe (strobe)
    );

`ifndef SYNTHESIS
    // The sequencer only goes idle on the beat that ends a numeral.
    a_idle_on_last: assert property (@(posedge clk) disable iff (!rst_n)
        $fell(busy) |-> strobe && last)
        else $error("busy dropped without a final letter");

    // A letter that is not the last one leaves the sequencer running.
    a_more_letters: assert property (@(posedge clk) disable iff (!rst_n)
        strobe && !last |-> busy)
        else $error("numeral ended without a final letter");

    // Every beat carries one of the seven numeral letters.
    a_legal_letter: assert property (@(posedge clk) disable iff (!rst_n)
        strobe |-> letter == i2r_pkg::LTR_C || letter == i2r_pkg::LTR_D ||
                   letter == i2r_pkg::LTR_I || letter == i2r_pkg::LTR_L ||
                   letter == i2r_pkg::LTR_M || letter == i2r_pkg::LTR_V ||
                   letter == i2r_pkg::LTR_X)
        else $error("illegal letter code");

    // A zero value starts nothing.
    a_zero_idle: assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy && value == '0 |=> !busy && !strobe)
        else $error("zero value started a numeral");
`endif

endmodule

`default_nettype wire
